### src/bba_pkg.sv
`timescale 1ns / 1ps
// Shared constants, state codes and helper functions for the buddy block allocator.
// No dependencies.
package bba_pkg;

    localparam int POOL_LOG2 = 12;                       // pool of 4096 bytes
    localparam int MIN_LOG2  = 4;                        // smallest block of 16 bytes
    localparam int LEVELS    = POOL_LOG2 - MIN_LOG2 + 1; // tree levels, root is level 0
    localparam int LVL_W     = $clog2(LEVELS);
    localparam int POS_W     = POOL_LOG2 - MIN_LOG2;     // block position on deepest level
    localparam int ROW_W     = 1 << POS_W;               // free marks per memory row
    localparam int OFF_W     = POOL_LOG2;
    localparam int SIZE_W    = 16;
    localparam int ALIGN_W   = 16;
    localparam int STAT_W    = 3;

    localparam logic [LVL_W-1:0] DEEPEST = LVL_W'(LEVELS - 1);

    localparam logic             CMD_ALLOC = 1'b0;
    localparam logic             CMD_FREE  = 1'b1;

    localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
    localparam logic [STAT_W-1:0] ST_ZERO_SIZE = 3'd1;
    localparam logic [STAT_W-1:0] ST_BAD_ALIGN = 3'd2;
    localparam logic [STAT_W-1:0] ST_NO_SPACE  = 3'd3;
    localparam logic [STAT_W-1:0] ST_MISALIGN  = 3'd4;

    typedef enum logic [3:0] {
        FSM_IDLE,
        FSM_SRCH_RD,
        FSM_SRCH_CHK,
        FSM_SPLIT_RD,
        FSM_SPLIT_CHK,
        FSM_FREE_RD,
        FSM_FREE_CHK,
        FSM_DONE
    } fsm_t;

    typedef struct packed {
        logic             any;
        logic [POS_W-1:0] idx;
    } lowest_t;

    // Find the lowest set free mark of a row
    function automatic lowest_t lowest_free(input logic [ROW_W-1:0] row);
        lowest_t res;
        res.any = 1'b0;
        res.idx = '0;
        for (int i = ROW_W - 1; i >= 0; i--) begin
            if (row[i])
            begin
                res.any = 1'b1;
                res.idx = POS_W'(i);
            end
        end
        return res;
    endfunction

    // Deepest level whose block still holds size bytes
    function automatic logic [LVL_W-1:0] level_of(input logic [SIZE_W-1:0] size);
        logic [SIZE_W-1:0] m;
        logic [4:0]        clg;
        logic [LVL_W-1:0]  lvl;
        m   = size - SIZE_W'(1);
        clg = '0;
        for (int i = 0; i < SIZE_W; i++) begin
            if (m[i])
            begin
                clg = 5'(i + 1);
            end
        end
        if (size <= SIZE_W'(1 << MIN_LOG2))
        begin
            lvl = DEEPEST;
        end
        else if (clg >= 5'(POOL_LOG2))
        begin
            lvl = '0;
        end
        else
        begin
            lvl = LVL_W'(5'(POOL_LOG2) - clg);
        end
        return lvl;
    endfunction

endpackage

### src/bba_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for requests and responses.
// Depends on bba_pkg.
interface bba_req_if;
    logic                          valid;
    logic                          ready;
    logic                          cmd;
    logic [bba_pkg::SIZE_W-1:0]    size;
    logic [bba_pkg::ALIGN_W-1:0]   alignment;
    logic [bba_pkg::OFF_W-1:0]     offset;

    modport source (output valid, cmd, size, alignment, offset, input ready);
    modport sink   (input valid, cmd, size, alignment, offset, output ready);
endinterface

interface bba_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [bba_pkg::STAT_W-1:0]    status;
    logic [bba_pkg::OFF_W-1:0]     block_offset;

    modport source (output valid, status, block_offset, input ready);
    modport sink   (input valid, status, block_offset, output ready);
endinterface

### src/bba_mem.sv
`timescale 1ns / 1ps
// Free-mark memory: one row of marks per tree level, registered read.
// Rows not yet written read as their reset value. Depends on bba_pkg.
module bba_mem
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        rd_en,
    input  logic [bba_pkg::LVL_W-1:0]   rd_addr,
    output logic [bba_pkg::ROW_W-1:0]   rd_data,
    input  logic                        wr_en,
    input  logic [bba_pkg::LVL_W-1:0]   wr_addr,
    input  logic [bba_pkg::ROW_W-1:0]   wr_data
);

    logic [bba_pkg::ROW_W-1:0]  mem [bba_pkg::LEVELS];
    logic [bba_pkg::LEVELS-1:0] row_valid_reg;
    logic [bba_pkg::ROW_W-1:0]  rd_raw_reg;
    logic                       rd_valid_reg;
    logic                       rd_root_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Track which rows hold written data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
        end
        else if (wr_en)
        begin
            row_valid_reg[wr_addr] <= 1'b1;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_raw_reg   <= mem[rd_addr];
            rd_valid_reg <= row_valid_reg[rd_addr];
            rd_root_reg  <= (rd_addr == '0);
        end
    end

    // Unwritten rows: only the root block is free
    assign rd_data = rd_valid_reg ? rd_raw_reg
                                  : bba_pkg::ROW_W'(rd_root_reg);

endmodule

### src/buddy_block_allocator_top.sv
`timescale 1ns / 1ps
// Buddy block allocator top level: request decode, level sequencer, response register.
// Depends on bba_pkg, bba_if and bba_mem.
//
// Buddy allocator over a 4096-byte pool with 16-byte minimum blocks (9 tree levels).
// Free marks live in one memory, one row per level, with a registered read;
// every request is handled by a sequencer that reads, modifies and writes back one
// row at a time, so one item is in work at a time. An allocate searches upward from
// its target level for a free block and splits it back down; a free merges with free
// buddies upward. Errors found at decode skip the walk. The response is registered,
// so a new request is taken while the previous response still waits.
module buddy_block_allocator_top
(
    input  logic         clk,
    input  logic         rst_n,
    bba_req_if.sink      req,
    bba_rsp_if.source    rsp
);

    localparam int LVL_W = bba_pkg::LVL_W;
    localparam int POS_W = bba_pkg::POS_W;
    localparam int ROW_W = bba_pkg::ROW_W;
    localparam int OFF_W = bba_pkg::OFF_W;

    bba_pkg::fsm_t state_reg, state_next;
    logic [LVL_W-1:0]               lvl_reg, lvl_next;
    logic [LVL_W-1:0]               tgt_reg, tgt_next;
    logic [POS_W-1:0]               pos_reg, pos_next;
    logic [bba_pkg::ALIGN_W-1:0]    align_reg, align_next;
    logic [bba_pkg::STAT_W-1:0]     res_stat_reg, res_stat_next;
    logic [OFF_W-1:0]               res_off_reg, res_off_next;
    logic                           outv_reg, outv_next;
    logic [bba_pkg::STAT_W-1:0]     out_stat_reg, out_stat_next;
    logic [OFF_W-1:0]               out_off_reg, out_off_next;

    logic                           rd_en;
    logic [LVL_W-1:0]               rd_addr;
    logic [ROW_W-1:0]               rd_data;
    logic                           wr_en;
    logic [LVL_W-1:0]               wr_addr;
    logic [ROW_W-1:0]               wr_data;

    bba_pkg::lowest_t               low;
    logic [LVL_W-1:0]               req_lvl;
    logic [OFF_W+POS_W-1:0]         off_wide;
    logic [OFF_W-1:0]               cand_off;
    logic [POS_W-1:0]               free_pos;
    logic [POS_W-1:0]               buddy;
    logic                           out_free;

    bba_mem u_mem
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    // Decode helpers
    assign low      = bba_pkg::lowest_free(rd_data);
    assign req_lvl  = bba_pkg::level_of(req.size);
    assign off_wide = (OFF_W+POS_W)'(low.idx) << (LVL_W'(OFF_W) - lvl_reg);
    assign cand_off = off_wide[OFF_W-1:0];
    assign free_pos = POS_W'(req.offset >> (LVL_W'(OFF_W) - req_lvl));
    assign buddy    = pos_reg ^ POS_W'(1);
    assign out_free = !outv_reg || rsp.ready;

    assign req.ready        = (state_reg == bba_pkg::FSM_IDLE);
    assign rsp.valid        = outv_reg;
    assign rsp.status       = out_stat_reg;
    assign rsp.block_offset = out_off_reg;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bba_pkg::FSM_IDLE;
            outv_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            outv_reg  <= outv_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        lvl_reg      <= lvl_next;
        tgt_reg      <= tgt_next;
        pos_reg      <= pos_next;
        align_reg    <= align_next;
        res_stat_reg <= res_stat_next;
        res_off_reg  <= res_off_next;
        out_stat_reg <= out_stat_next;
        out_off_reg  <= out_off_next;
    end

    // Sequencer
    always_comb
    begin
        state_next    = state_reg;
        lvl_next      = lvl_reg;
        tgt_next      = tgt_reg;
        pos_next      = pos_reg;
        align_next    = align_reg;
        res_stat_next = res_stat_reg;
        res_off_next  = res_off_reg;
        outv_next     = outv_reg && !rsp.ready;
        out_stat_next = out_stat_reg;
        out_off_next  = out_off_reg;
        rd_en         = 1'b0;
        rd_addr       = lvl_reg;
        wr_en         = 1'b0;
        wr_addr       = lvl_reg;
        wr_data       = rd_data;

        case (state_reg)
            bba_pkg::FSM_IDLE:
            begin
                res_off_next  = '0;
                res_stat_next = bba_pkg::ST_OK;
                lvl_next      = req_lvl;
                tgt_next      = req_lvl;
                align_next    = req.alignment;
                pos_next      = free_pos;
                if (req.valid)
                begin
                    if (req.cmd == bba_pkg::CMD_FREE)
                    begin
                        state_next = bba_pkg::FSM_FREE_RD;
                    end
                    else if (req.size == '0)
                    begin
                        res_stat_next = bba_pkg::ST_ZERO_SIZE;
                        state_next    = bba_pkg::FSM_DONE;
                    end
                    else if (req.alignment == '0 ||
                             (req.alignment & (req.alignment - 16'd1)) != '0)
                    begin
                        res_stat_next = bba_pkg::ST_BAD_ALIGN;
                        state_next    = bba_pkg::FSM_DONE;
                    end
                    else if (req.size > 16'(1 << OFF_W))
                    begin
                        res_stat_next = bba_pkg::ST_NO_SPACE;
                        state_next    = bba_pkg::FSM_DONE;
                    end
                    else
                    begin
                        state_next = bba_pkg::FSM_SRCH_RD;
                    end
                end
            end

            bba_pkg::FSM_SRCH_RD:
            begin
                rd_en      = 1'b1;
                state_next = bba_pkg::FSM_SRCH_CHK;
            end

            // Look for a free block, take it or split it toward the target
            bba_pkg::FSM_SRCH_CHK:
            begin
                if (low.any)
                begin
                    if (lvl_reg == tgt_reg)
                    begin
                        state_next = bba_pkg::FSM_DONE;
                        if ((cand_off & OFF_W'(align_reg - 16'd1)) != '0)
                        begin
                            res_stat_next = bba_pkg::ST_MISALIGN;
                        end
                        else
                        begin
                            wr_en        = 1'b1;
                            wr_data      = rd_data & ~(ROW_W'(1) << low.idx);
                            res_off_next = cand_off;
                        end
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        wr_data    = rd_data & ~(ROW_W'(1) << low.idx);
                        pos_next   = low.idx;
                        state_next = bba_pkg::FSM_SPLIT_RD;
                    end
                end
                else if (lvl_reg == '0)
                begin
                    res_stat_next = bba_pkg::ST_NO_SPACE;
                    state_next    = bba_pkg::FSM_DONE;
                end
                else
                begin
                    lvl_next   = lvl_reg - LVL_W'(1);
                    state_next = bba_pkg::FSM_SRCH_RD;
                end
            end

            bba_pkg::FSM_SPLIT_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = lvl_reg + LVL_W'(1);
                lvl_next   = lvl_reg + LVL_W'(1);
                state_next = bba_pkg::FSM_SPLIT_CHK;
            end

            // Mark both halves free one level down
            bba_pkg::FSM_SPLIT_CHK:
            begin
                wr_en      = 1'b1;
                wr_data    = rd_data | (ROW_W'(3) << {pos_reg, 1'b0});
                state_next = bba_pkg::FSM_SRCH_RD;
            end

            bba_pkg::FSM_FREE_RD:
            begin
                rd_en      = 1'b1;
                state_next = bba_pkg::FSM_FREE_CHK;
            end

            // Merge with a free buddy or mark the block free
            bba_pkg::FSM_FREE_CHK:
            begin
                wr_en = 1'b1;
                if (lvl_reg != '0 && rd_data[buddy])
                begin
                    wr_data    = rd_data & ~(ROW_W'(1) << buddy);
                    pos_next   = pos_reg >> 1;
                    lvl_next   = lvl_reg - LVL_W'(1);
                    state_next = bba_pkg::FSM_FREE_RD;
                end
                else
                begin
                    wr_data    = rd_data | (ROW_W'(1) << pos_reg);
                    state_next = bba_pkg::FSM_DONE;
                end
            end

            // Hand the result to the response register
            bba_pkg::FSM_DONE:
            begin
                if (out_free)
                begin
                    outv_next     = 1'b1;
                    out_stat_next = res_stat_reg;
                    out_off_next  = res_off_reg;
                    state_next    = bba_pkg::FSM_IDLE;
                end
            end

            default:
            begin
                state_next = bba_pkg::FSM_IDLE;
            end
        endcase
    end

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for buddy_block_allocator_top: directed and random allocate/free
// traffic is predicted by a behavioral free-mark tree and compared item by item.
// Depends on bba_pkg, bba_if and buddy_block_allocator_top.
module tb_top;

    localparam int NODES    = 511;
    localparam int NLEV     = 9;
    localparam int POOL     = 4096;
    localparam int MINB     = 16;
    localparam int N_RANDOM = 1600;

    typedef struct {
        logic        cmd;
        logic [15:0] size;
        logic [15:0] alignment;
        logic [11:0] offset;
    } alloc_req_t;

    typedef struct {
        logic [2:0]  status;
        logic [11:0] block_offset;
    } alloc_rsp_t;

    typedef struct {
        int off;
        int bytes;
    } live_blk_t;

    logic clk;
    logic rst_n;
    int   errors;

    bba_req_if req ();
    bba_rsp_if rsp ();

    buddy_block_allocator_top uut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    alloc_req_t pending_q[$];
    alloc_rsp_t expected_q[$];
    live_blk_t  live_q[$];

    // Free-mark tree of the predictor
    bit tree_free[NODES];

    bit calm;
    bit took;
    int send_gap;
    int recv_gap;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic int node_of(int lvl, int pos);
        int i;
        i = (1 << lvl) - 1 + pos;
        return (i < NODES) ? i : 0;
    endfunction

    function automatic int first_free(int lvl);
        for (int p = 0; p < (1 << lvl); p++) begin
            if (tree_free[node_of(lvl, p)])
            begin
                return p;
            end
        end
        return -1;
    endfunction

    // Apply one request to the tree and compute its answer
    function automatic alloc_rsp_t allocate_or_free(alloc_req_t it);
        alloc_rsp_t r;
        int need;
        int cur;
        int tgt;
        int s;
        int p;
        int boff;
        int lvl;
        int bs;
        int pos;
        int sz;
        int al;
        r.status       = bba_pkg::ST_OK;
        r.block_offset = '0;
        sz = it.size;
        al = it.alignment;
        if (it.cmd == bba_pkg::CMD_ALLOC)
        begin
            need = 1;
            while (need < sz)
                need = need << 1;
            if (need < MINB)
                need = MINB;
            if (sz == 0)
                r.status = bba_pkg::ST_ZERO_SIZE;
            else if (al == 0 || (al & (al - 1)) != 0)
                r.status = bba_pkg::ST_BAD_ALIGN;
            else if (need > POOL)
                r.status = bba_pkg::ST_NO_SPACE;
            else
            begin
                cur = POOL;
                tgt = 0;
                while (cur > need && tgt + 1 < NLEV)
                begin
                    cur = cur >> 1;
                    tgt++;
                end
                s = tgt;
                while (s > 0 && first_free(s) < 0)
                    s--;
                if (first_free(s) < 0)
                    r.status = bba_pkg::ST_NO_SPACE;
                else
                begin
                    // split down to the target level
                    while (s < tgt)
                    begin
                        p = first_free(s);
                        tree_free[node_of(s, p)] = 0;
                        tree_free[node_of(s + 1, 2 * p)] = 1;
                        tree_free[node_of(s + 1, 2 * p + 1)] = 1;
                        s++;
                    end
                    p = first_free(tgt);
                    boff = p * (POOL >> tgt);
                    if ((boff & (al - 1)) != 0)
                        r.status = bba_pkg::ST_MISALIGN;
                    else
                    begin
                        tree_free[node_of(tgt, p)] = 0;
                        r.block_offset = boff[11:0];
                    end
                end
            end
        end
        else
        begin
            lvl = 0;
            bs  = POOL;
            while (lvl + 1 < NLEV && bs / 2 >= sz)
            begin
                bs = bs >> 1;
                lvl++;
            end
            pos = int'(it.offset) / bs;
            // merge with free buddies upward
            while (lvl > 0)
            begin
                if (!tree_free[node_of(lvl, pos ^ 1)])
                    break;
                tree_free[node_of(lvl, pos ^ 1)] = 0;
                pos = pos >> 1;
                lvl--;
            end
            tree_free[node_of(lvl, pos)] = 1;
        end
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    // Predict on accepted requests, check accepted responses
    always @(posedge clk)
    begin
        alloc_req_t it;
        alloc_rsp_t ex;
        live_blk_t  lb;
        if (rst_n && req.valid && req.ready)
        begin
            it.cmd       = req.cmd;
            it.size      = req.size;
            it.alignment = req.alignment;
            it.offset    = req.offset;
            ex = allocate_or_free(it);
            expected_q.insert(expected_q.size(), ex);
            if (it.cmd == bba_pkg::CMD_ALLOC && ex.status == bba_pkg::ST_OK)
            begin
                lb.off   = ex.block_offset;
                lb.bytes = it.size;
                live_q.insert(live_q.size(), lb);
            end
            took = 1'b1;
        end
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected item status=%0d block_offset=%0d",
                         $time, rsp.status, rsp.block_offset);
                errors++;
            end
            else
            begin
                ex = expected_q[0];
                expected_q.delete(0);
                if (rsp.status !== ex.status)
                begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, ex.status, rsp.status);
                    errors++;
                end
                if (rsp.block_offset !== ex.block_offset)
                begin
                    $display("%0t: block_offset expected %0d actual %0d",
                             $time, ex.block_offset, rsp.block_offset);
                    errors++;
                end
            end
        end
    end

    // Drive requests from the pending queue
    always @(negedge clk)
    begin
        alloc_req_t it;
        if (rst_n && (!req.valid || took))
        begin
            took = 1'b0;
            if (send_gap > 0 || pending_q.size() == 0)
            begin
                if (send_gap > 0)
                    send_gap--;
                req.valid <= 1'b0;
            end
            else
            begin
                it = pending_q[0];
                pending_q.delete(0);
                req.cmd       <= it.cmd;
                req.size      <= it.size;
                req.alignment <= it.alignment;
                req.offset    <= it.offset;
                req.valid     <= 1'b1;
                send_gap = pick_gap();
            end
        end
    end

    // Stall the response side
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (recv_gap > 0)
            begin
                recv_gap--;
                rsp.ready <= 1'b0;
            end
            else
            begin
                rsp.ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    recv_gap = pick_gap();
            end
        end
    end

    task automatic queue_req(logic c, int sz, int al, int off);
        alloc_req_t it;
        it.cmd       = c;
        it.size      = sz[15:0];
        it.alignment = al[15:0];
        it.offset    = off[11:0];
        pending_q.insert(pending_q.size(), it);
    endtask

    task automatic queue_random();
        int r;
        int k;
        int sz;
        int al;
        live_blk_t lb;
        r = $urandom_range(0, 99);
        if (r < 50)
        begin
            // well-formed allocate, mostly small
            sz = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 4096)
                                             : $urandom_range(1, 256);
            al = 1 << $urandom_range(0, ($urandom_range(0, 7) == 0) ? 15 : 6);
            queue_req(bba_pkg::CMD_ALLOC, sz, al, $urandom_range(0, 4095));
        end
        else if (r < 88 && live_q.size() > 0)
        begin
            k  = $urandom_range(0, live_q.size() - 1);
            lb = live_q[k];
            live_q.delete(k);
            queue_req(bba_pkg::CMD_FREE, lb.bytes, $urandom_range(0, 65535), lb.off);
        end
        else if (r < 94)
            queue_req(bba_pkg::CMD_ALLOC, $urandom_range(0, 65535),
                      $urandom_range(0, 65535), $urandom_range(0, 4095));
        else
            queue_req(bba_pkg::CMD_FREE, $urandom_range(0, 65535),
                      $urandom_range(0, 65535), $urandom_range(0, 4095));
    endtask

    // Reset, stimulus and end of run
    initial
    begin
        errors    = 0;
        calm      = 1'b0;
        took      = 1'b0;
        send_gap  = 0;
        recv_gap  = 0;
        rst_n     = 1'b0;
        req.valid = 1'b0;
        req.cmd   = bba_pkg::CMD_ALLOC;
        req.size  = '0;
        req.alignment = '0;
        req.offset    = '0;
        rsp.ready = 1'b0;
        for (int i = 0; i < NODES; i++)
            tree_free[i] = (i == 0);
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed corner cases
        queue_req(bba_pkg::CMD_ALLOC, 0, 1, 0);          // zero size
        queue_req(bba_pkg::CMD_ALLOC, 16, 0, 0);         // zero alignment
        queue_req(bba_pkg::CMD_ALLOC, 16, 3, 0);         // alignment not a power of two
        queue_req(bba_pkg::CMD_ALLOC, 65535, 1, 0);      // larger than the pool
        queue_req(bba_pkg::CMD_ALLOC, 5000, 32768, 0);
        queue_req(bba_pkg::CMD_ALLOC, 4096, 4096, 0);    // whole pool
        queue_req(bba_pkg::CMD_ALLOC, 1, 1, 0);          // pool exhausted
        queue_req(bba_pkg::CMD_FREE, 65535, 65535, 4095);// root freed
        queue_req(bba_pkg::CMD_ALLOC, 1, 1, 0);          // small request
        queue_req(bba_pkg::CMD_ALLOC, 16, 32, 0);        // misaligned block
        queue_req(bba_pkg::CMD_ALLOC, 16, 16, 0);
        queue_req(bba_pkg::CMD_ALLOC, 8, 32768, 0);      // misaligned, large alignment
        queue_req(bba_pkg::CMD_FREE, 0, 0, 0);           // zero size free
        queue_req(bba_pkg::CMD_FREE, 0, 0, 0);           // double free
        queue_req(bba_pkg::CMD_FREE, 16, 0, 4095);       // unaligned offset
        queue_req(bba_pkg::CMD_FREE, 16, 0, 16);
        queue_req(bba_pkg::CMD_ALLOC, 2048, 2048, 0);
        queue_req(bba_pkg::CMD_ALLOC, 2049, 1, 0);
        queue_req(bba_pkg::CMD_FREE, 2048, 1, 2048);     // frees the 2048-byte block allocated above
        queue_req(bba_pkg::CMD_FREE, 4096, 1, 0);
        queue_req(bba_pkg::CMD_ALLOC, 17, 65535, 0);

        for (int n = 0; n < N_RANDOM; n++)
        begin
            while (pending_q.size() > 1)
            begin
                @(posedge clk);
                #1;
            end
            if ($urandom_range(0, 199) == 0)
                calm = !calm;
            queue_random();
        end

        while (pending_q.size() > 0 || req.valid || expected_q.size() > 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
